>>> rtl/lpre_pkg.sv
// Package: payload types, opcodes, sequencer states, constants and escape checks of the row encoder.
package lpre_pkg;

  localparam logic [28:0] MaxBytesReset = 29'd65536;
  localparam int unsigned NumDigits     = 20;

  typedef enum logic [3:0] {
    OP_TABLE   = 4'd0,
    OP_TAG     = 4'd1,
    OP_FIELD   = 4'd2,
    OP_NAME    = 4'd3,
    OP_EQUALS  = 4'd4,
    OP_TAGVAL  = 4'd5,
    OP_QUOTE   = 4'd6,
    OP_STRING  = 4'd7,
    OP_BOOL    = 4'd8,
    OP_INT     = 4'd9,
    OP_TSFIELD = 4'd10,
    OP_ENDTIME = 4'd11,
    OP_ENDNOW  = 4'd12
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRE,
    ST_SCALE,
    ST_CONV,
    ST_SIGN,
    ST_DIGITS,
    ST_BYTE,
    ST_SUFFIX
  } state_e;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [7:0]  data_byte;
    logic [63:0] int_value;
    logic [1:0]  time_unit;
    logic        bool_value;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       last_of_item;
    logic       overflowed;
  } out_word_t;

  // one character request from the sequencer to the budget stage
  typedef struct packed {
    logic       req;
    logic [7:0] ch;
    logic       last;
  } char_req_t;

  function automatic logic is_name_esc(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h2C) || (b == 8'h3D);
  endfunction

  function automatic logic is_str_esc(input logic [7:0] b);
    return (b == 8'h5C) || (b == 8'h22);
  endfunction

endpackage

>>> rtl/line_protocol_row_encoder.sv
// Top level of the line-protocol row encoder: token sequencer and decimal unit.
// Takes one row token at a time and writes its line-protocol text, one output word per
// character, each checked against the max_bytes budget (suppressed words still appear,
// with out_valid low). The block is busy for the whole token: a byte token goes through
// accept, then character, or accept, escape check or backslash, character when it passes
// the escape step; a numeric token is scaled (a shared adder does shift-and-add by 1000
// per unit step, up to three steps), converted binary-to-BCD (one shift-add-3 step per
// cycle over 20 digits, plus setup and finish), then written one character at a time.
// Output backpressure stalls the sequencer; a finished word waits in the output register.
module line_protocol_row_encoder #(
  parameter logic [28:0] MaxBytesRst = lpre_pkg::MaxBytesReset
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  lpre_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lpre_pkg::out_word_t  out_word_o,
  input  logic                 cfg_we_i,
  input  logic [28:0]          cfg_wdata_i
);
  import lpre_pkg::*;

  state_e       state_q, state_d;
  in_word_t     tok_q, tok_d;
  logic [28:0]  max_q;
  logic         fs_q, fs_d;
  logic [63:0]  mag_q, mag_d;      // magnitude being scaled/converted
  logic         neg_q, neg_d;
  logic [79:0]  bcd_q, bcd_d;
  logic [6:0]   cnt_q, cnt_d;      // iteration counter
  logic [1:0]   unit_q, unit_d;    // remaining x1000 steps
  logic [4:0]   dig_q, dig_d;      // digit index being emitted
  logic [63:0]  acc_q, acc_d;      // scaling accumulator
  logic         sovf_q, sovf_d;    // scaling overflow pending
  logic         set_ovf;
  char_req_t    creq;
  logic         busy, ovf;
  logic         accept;
  logic         step;              // character taken this cycle
  logic [79:0]  bcd_adj;
  logic [64:0]  sum;
  logic [3:0]   cur_dig;
  logic [4:0]   top_dig;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign step       = creq.req && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MaxBytesRst;
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

  // add-3 correction across all digits, then shift in a magnitude bit
  always_comb begin
    bcd_adj = bcd_q;
    for (int k = 0; k < NumDigits; k++) begin
      if (bcd_q[k*4 +: 4] >= 4'd5) bcd_adj[k*4 +: 4] = bcd_q[k*4 +: 4] + 4'd3;
    end
  end

  // most significant nonzero digit index
  always_comb begin
    top_dig = 5'd0;
    for (int k = 0; k < NumDigits; k++) begin
      if (bcd_q[k*4 +: 4] != 4'd0) top_dig = 5'(k);
    end
  end

  assign cur_dig = bcd_q[dig_q*4 +: 4];
  // shared adder for x1000 scaling: acc += mag << shift where multiplier bit set
  assign sum = {1'b0, acc_q} + {1'b0, mag_q};

  // next state
  always_comb begin
    state_d = state_q;
    tok_d   = tok_q;
    fs_d    = fs_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    bcd_d   = bcd_q;
    cnt_d   = cnt_q;
    unit_d  = unit_q;
    dig_d   = dig_q;
    acc_d   = acc_q;
    sovf_d  = sovf_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          tok_d  = in_word_i;
          neg_d  = in_word_i.int_value[63];
          mag_d  = in_word_i.int_value[63] ? (64'd0 - in_word_i.int_value)
                                           : in_word_i.int_value;
          unit_d = in_word_i.time_unit;
          acc_d  = '0;
          cnt_d  = '0;
          sovf_d = 1'b0;
          case (opcode_e'(in_word_i.opcode))
            OP_TABLE:   begin fs_d = 1'b0; state_d = ST_PRE; end
            OP_NAME, OP_TAGVAL, OP_STRING: state_d = ST_PRE;
            OP_TAG, OP_EQUALS, OP_QUOTE, OP_BOOL, OP_ENDNOW: state_d = ST_BYTE;
            OP_FIELD:   state_d = ST_BYTE;
            OP_INT: begin unit_d = 2'd0; state_d = ST_CONV; end
            OP_TSFIELD: state_d = ST_SCALE;
            OP_ENDTIME: state_d = ST_PRE;
            default:    state_d = ST_IDLE;
          endcase
          if (in_word_i.opcode == OP_TSFIELD && in_word_i.time_unit == 2'd0) begin
            state_d = ST_CONV;
          end
        end
      end
      ST_PRE: begin
        // escape backslash, or the leading space of end-with-time
        if (step) begin
          if (tok_q.opcode == OP_ENDTIME) begin
            state_d = (unit_q == 2'd0) ? ST_CONV : ST_SCALE;
          end else begin
            state_d = ST_BYTE;
          end
        end else if (tok_q.opcode != OP_ENDTIME && !creq.req) begin
          state_d = ST_BYTE;
        end
      end
      ST_SCALE: begin
        // one bit of x1000 (= 0b1111101000) per cycle; magnitude shifted left
        if (cnt_q < 7'd10) begin
          if (cnt_q == 7'd3 || cnt_q >= 7'd5) begin
            acc_d = sum[63:0];
            if (sum[64]) sovf_d = 1'b1;
          end
          if (mag_q[63]) begin
            if (cnt_q != 7'd9) sovf_d = 1'b1;
          end
          mag_d = {mag_q[62:0], 1'b0};
          cnt_d = cnt_q + 7'd1;
        end else begin
          mag_d  = acc_q;
          acc_d  = '0;
          cnt_d  = '0;
          unit_d = unit_q - 2'd1;
          if (unit_q == 2'd1 || sovf_q) state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        if (cnt_q == 7'd0) begin
          // signed range check after scaling
          if (tok_q.opcode != OP_INT && tok_q.time_unit != 2'd0 && !sovf_q) begin
            if (neg_q ? (mag_q > 64'h8000_0000_0000_0000) : mag_q[63]) sovf_d = 1'b1;
          end
          if (sovf_q || (tok_q.opcode != OP_INT && tok_q.time_unit != 2'd0 &&
              (neg_q ? (mag_q > 64'h8000_0000_0000_0000) : mag_q[63]))) begin
            mag_d = '0;
            neg_d = 1'b0;
          end
          bcd_d = '0;
          cnt_d = 7'd1;
        end else if (cnt_q <= 7'd64) begin
          bcd_d = {bcd_adj[78:0], mag_q[63]};
          mag_d = {mag_q[62:0], 1'b0};
          cnt_d = cnt_q + 7'd1;
        end else begin
          dig_d   = top_dig;
          state_d = neg_q ? ST_SIGN : ST_DIGITS;
        end
      end
      ST_SIGN:   if (step) state_d = ST_DIGITS;
      ST_DIGITS: begin
        if (step) begin
          if (dig_q == 5'd0) state_d = ST_SUFFIX;
          else dig_d = dig_q - 5'd1;
        end
      end
      ST_BYTE: begin
        if (step) begin
          state_d = ST_IDLE;
          if (tok_q.opcode == OP_FIELD) fs_d = 1'b1;
          if (tok_q.opcode == OP_ENDNOW) fs_d = 1'b0;
        end
      end
      ST_SUFFIX: begin
        if (step) begin
          state_d = ST_IDLE;
          if (tok_q.opcode == OP_ENDTIME) fs_d = 1'b0;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // character requests and overflow raise
  always_comb begin
    creq    = '0;
    set_ovf = 1'b0;
    case (state_q)
      ST_PRE: begin
        if (tok_q.opcode == OP_ENDTIME) begin
          creq.req = 1'b1; creq.ch = 8'h20;
        end else if (tok_q.opcode == OP_STRING) begin
          creq.req = is_str_esc(tok_q.data_byte) || tok_q.data_byte == 8'h0A ||
                     tok_q.data_byte == 8'h0D;
          creq.ch  = 8'h5C;
        end else if (tok_q.opcode == OP_TAGVAL) begin
          creq.req = is_name_esc(tok_q.data_byte) || tok_q.data_byte == 8'h0A ||
                     tok_q.data_byte == 8'h0D;
          creq.ch  = 8'h5C;
        end else begin
          creq.req = is_name_esc(tok_q.data_byte);
          creq.ch  = 8'h5C;
        end
      end
      ST_CONV: begin
        if (cnt_q == 7'd0 && tok_q.opcode != OP_INT && tok_q.time_unit != 2'd0) begin
          set_ovf = sovf_q || (neg_q ? (mag_q > 64'h8000_0000_0000_0000) : mag_q[63]);
        end
      end
      ST_SIGN:   begin creq.req = 1'b1; creq.ch = 8'h2D; end
      ST_DIGITS: begin creq.req = 1'b1; creq.ch = {4'h3, cur_dig}; end
      ST_SUFFIX: begin
        creq.req  = 1'b1;
        creq.last = 1'b1;
        case (opcode_e'(tok_q.opcode))
          OP_INT:     creq.ch = 8'h69;
          OP_TSFIELD: creq.ch = 8'h74;
          default:    creq.ch = 8'h0A;
        endcase
      end
      ST_BYTE: begin
        creq.req  = 1'b1;
        creq.last = 1'b1;
        case (opcode_e'(tok_q.opcode))
          OP_TAG:    creq.ch = 8'h2C;
          OP_FIELD:  creq.ch = fs_q ? 8'h2C : 8'h20;
          OP_EQUALS: creq.ch = 8'h3D;
          OP_QUOTE:  creq.ch = 8'h22;
          OP_BOOL:   creq.ch = tok_q.bool_value ? 8'h74 : 8'h66;
          OP_ENDNOW: creq.ch = 8'h0A;
          OP_TAGVAL, OP_STRING: begin
            case (tok_q.data_byte)
              8'h0A:   creq.ch = 8'h6E;
              8'h0D:   creq.ch = 8'h72;
              default: creq.ch = tok_q.data_byte;
            endcase
          end
          default:   creq.ch = tok_q.data_byte;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fs_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      fs_q    <= fs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q  <= tok_d;
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    bcd_q  <= bcd_d;
    cnt_q  <= cnt_d;
    unit_q <= unit_d;
    dig_q  <= dig_d;
    acc_q  <= acc_d;
    sovf_q <= sovf_d;
  end

  lpre_budget u_budget (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_bytes_i (max_q),
    .req_i       (creq),
    .set_ovf_i   (set_ovf),
    .busy_o      (busy),
    .ovf_o       (ovf),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  logic unused_ovf;
  assign unused_ovf = ovf;
endmodule

>>> rtl/lpre_budget.sv
// Byte budget: counts emitted characters, sticky overflow, and the output register.
module lpre_budget (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [28:0]           max_bytes_i,
  input  lpre_pkg::char_req_t   req_i,
  input  logic                  set_ovf_i,
  output logic                  busy_o,
  output logic                  ovf_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output lpre_pkg::out_word_t   out_word_o
);
  import lpre_pkg::*;

  logic [28:0] cnt_q, cnt_d;
  logic        ovf_q, ovf_d;
  logic        vld_q, vld_d;
  out_word_t   word_q, word_d;
  logic        emit;

  assign busy_o = vld_q && out_stall_i;
  assign ovf_o  = ovf_q;

  always_comb begin
    cnt_d  = cnt_q;
    ovf_d  = ovf_q | set_ovf_i;
    vld_d  = vld_q && out_stall_i;
    word_d = word_q;
    emit   = 1'b0;
    if (req_i.req && !busy_o) begin
      if (!ovf_q) begin
        if (cnt_q >= max_bytes_i) begin
          ovf_d = 1'b1;
        end else begin
          emit  = 1'b1;
          cnt_d = cnt_q + 29'd1;
        end
      end
      vld_d               = 1'b1;
      word_d.out_byte     = emit ? req_i.ch : 8'd0;
      word_d.out_valid    = emit;
      word_d.last_of_item = req_i.last;
      word_d.overflowed   = ovf_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
      vld_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign out_valid_o = vld_q;
  assign out_word_o  = word_q;
endmodule

>>> rtl/lpre_checker.sv
// Port checker for the row encoder, bound to the top level.
module lpre_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input lpre_pkg::out_word_t out_word_o
);
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i)
    else $error("offered input word withdrawn while stalled");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");
  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_word_o.overflowed ##1 out_valid_o |->
    out_word_o.overflowed)
    else $error("overflow cleared");
  a_suppr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.out_valid |-> out_word_o.out_byte == 8'd0)
    else $error("suppressed word carries a byte");
  a_ovf_suppress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.out_valid |-> !out_word_o.overflowed)
    else $error("valid byte after overflow");
endmodule

bind line_protocol_row_encoder lpre_checker u_lpre_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

>>> verif/tb_top.sv
// Testbench for the row encoder: directed token table, then random rows, checked per word.
`timescale 1ns / 100ps

module tb_top;
  import lpre_pkg::*;

  // The limit covers every token at full length, with the longest receiver stall on
  // each of its 22 words.
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned NumRandom  = 410;
  localparam int unsigned DrainWait  = 400;
  localparam int unsigned MaxShown   = 10;
  localparam int unsigned LongHold   = 600;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_word_o;
  logic      cfg_we_i;
  logic [28:0] cfg_wdata_i;

  line_protocol_row_encoder uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Encoder state as the scoreboard sees it.
  logic [28:0] budget;
  logic        have_fields;
  logic [28:0] chars_sent;
  logic        ovf_sticky;

  out_word_t   pending_chars[$];
  string       typed_exp[$];  // typed text of directed rows, in send order
  int unsigned mismatches;
  int unsigned cycles;
  logic        long_hold;  // receiver holds off for a long stretch

  // Budget check for one character; appends the word it produces.
  function automatic void emit_char(input logic [7:0] c);
    out_word_t w;
    w = '0;
    if (!ovf_sticky) begin
      if (chars_sent >= budget) begin
        ovf_sticky = 1'b1;
      end else begin
        w.out_valid = 1'b1;
        w.out_byte  = c;
        chars_sent  = chars_sent + 29'd1;
      end
    end
    w.overflowed = ovf_sticky;
    pending_chars.push_back(w);
  endfunction

  function automatic void emit_decimal(input logic [63:0] raw);
    logic [63:0] mag;
    logic [7:0]  digs[20];
    int          n;
    n   = 0;
    mag = raw[63] ? (64'd0 - raw) : raw;
    if (mag == 64'd0) begin
      emit_char("0");
      return;
    end
    while (mag != 64'd0) begin
      digs[n] = 8'h30 + 8'(mag % 64'd10);
      mag     = mag / 64'd10;
      n++;
    end
    if (raw[63]) emit_char("-");
    while (n > 0) begin
      n--;
      emit_char(digs[n]);
    end
  endfunction

  function automatic logic [63:0] scale_to_ns(input logic [63:0] raw, input logic [1:0] unit);
    longint v;
    longint mul;
    v = longint'(raw);
    case (unit)
      2'd1: mul = 64'sd1000;
      2'd2: mul = 64'sd1000000;
      2'd3: mul = 64'sd1000000000;
      default: return raw;
    endcase
    if (v > 64'sh7FFF_FFFF_FFFF_FFFF / mul ||
        v < longint'(64'h8000_0000_0000_0000) / mul) begin
      ovf_sticky = 1'b1;
      return 64'd0;
    end
    return 64'(v * mul);
  endfunction

  function automatic void escaped_text(input logic [7:0] b, input logic str_mode);
    if (b == 8'h0A) begin
      emit_char("\\");
      emit_char("n");
    end else if (b == 8'h0D) begin
      emit_char("\\");
      emit_char("r");
    end else begin
      if (str_mode ? (b == "\\" || b == "\"") : (b == " " || b == "," || b == "="))
        emit_char("\\");
      emit_char(b);
    end
  endfunction

  // Works out the characters one token writes, queued in order.
  function automatic void encode_token(input in_word_t t);
    int first;
    first = pending_chars.size();
    case (t.opcode)
      OP_TABLE, OP_NAME: begin
        if (t.opcode == OP_TABLE) have_fields = 1'b0;
        if (t.data_byte == " " || t.data_byte == "," || t.data_byte == "=") emit_char("\\");
        emit_char(t.data_byte);
      end
      OP_TAG:    emit_char(",");
      OP_FIELD: begin
        emit_char(have_fields ? "," : " ");
        have_fields = 1'b1;
      end
      OP_EQUALS: emit_char("=");
      OP_TAGVAL: escaped_text(t.data_byte, 1'b0);
      OP_QUOTE:  emit_char("\"");
      OP_STRING: escaped_text(t.data_byte, 1'b1);
      OP_BOOL:   emit_char(t.bool_value ? "t" : "f");
      OP_INT: begin
        emit_decimal(t.int_value);
        emit_char("i");
      end
      OP_TSFIELD: begin
        emit_decimal(scale_to_ns(t.int_value, t.time_unit));
        emit_char("t");
      end
      OP_ENDTIME: begin
        emit_char(" ");
        emit_decimal(scale_to_ns(t.int_value, t.time_unit));
        emit_char(8'h0A);
        have_fields = 1'b0;
      end
      OP_ENDNOW: begin
        emit_char(8'h0A);
        have_fields = 1'b0;
      end
      default: ;  // unused codes write nothing
    endcase
    if (pending_chars.size() > first)
      pending_chars[pending_chars.size() - 1].last_of_item = 1'b1;
  endfunction

  // Typed text of a directed row against the characters queued for it.
  function automatic void check_typed(input string s, input int base);
    logic  ok;
    string got;
    got = "";
    for (int k = base; k < pending_chars.size(); k++)
      got = $sformatf("%s%c", got, pending_chars[k].out_byte);
    ok = (pending_chars.size() - base) == s.len();
    for (int k = 0; ok && k < s.len(); k++)
      ok = pending_chars[base + k].out_valid && (pending_chars[base + k].out_byte == s[k]);
    if (!ok) begin
      mismatches++;
      if (mismatches <= MaxShown)
        $display("ERROR: token text exp \"%s\" got \"%s\"", s, got);
    end
  endfunction

  // Scoreboard: accepted tokens run through the predictor, accepted words are checked.
  always @(posedge clk_i) begin
    int    base;
    string exp_s;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        base = pending_chars.size();
        encode_token(in_word_i);
        if (typed_exp.size() != 0) begin
          exp_s = typed_exp.pop_front();
          if (exp_s.len() != 0) check_typed(exp_s, base);
        end
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_chars.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxShown)
            $display("ERROR: unexpected word %h", out_word_o);
        end else begin
          out_word_t exp_w;
          exp_w = pending_chars.pop_front();
          if (out_word_o !== exp_w) begin
            mismatches++;
            if (mismatches <= MaxShown)
              $display("ERROR: byte %h/%h valid %b/%b last %b/%b ovf %b/%b (exp/got)",
                       exp_w.out_byte, out_word_o.out_byte, exp_w.out_valid,
                       out_word_o.out_valid, exp_w.last_of_item, out_word_o.last_of_item,
                       exp_w.overflowed, out_word_o.overflowed);
          end
        end
      end
    end
  end

  // Receiver: a random wait after each word taken, one long hold-off on request.
  initial begin
    int unsigned gap;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
        long_hold = 1'b0;
        out_stall_i <= 1'b0;
      end else if (out_valid_o && !out_stall_i) begin
        gap = $urandom_range(0, 14);
        if (gap != 0) begin
          out_stall_i <= 1'b1;
          repeat (gap) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // Cycle counter and timeout.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Valid stays high after the accepting edge until the next token or a drain.
  task automatic send_token(input in_word_t t, input logic quiet);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 14);
    if ($urandom_range(0, 4) == 0) gap = 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= t;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic set_budget(input logic [28:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    budget = v;
  endtask

  function automatic in_word_t make_token(input logic [3:0] op, input logic [7:0] b,
                                          input logic [63:0] v, input logic [1:0] u,
                                          input logic bv);
    in_word_t t;
    t.opcode = op; t.data_byte = b; t.int_value = v; t.time_unit = u; t.bool_value = bv;
    return t;
  endfunction

  function automatic in_word_t random_token(input logic [3:0] op);
    in_word_t t;
    logic [63:0] v;
    case ($urandom_range(0, 4))
      0: v = {$urandom, $urandom};
      1: v = 64'($signed($urandom_range(0, 2000)) - 1000);
      2: v = {32'd0, $urandom} >> $urandom_range(0, 31);
      3: v = {$urandom, $urandom} >> $urandom_range(20, 40);
      default: v = -({32'd0, $urandom});
    endcase
    t = make_token(op, 8'($urandom), v, 2'($urandom), 1'($urandom));
    if ($urandom_range(0, 3) == 0) t.data_byte = "\\";
    if ($urandom_range(0, 5) == 0) t.data_byte = " ";
    if ($urandom_range(0, 7) == 0) t.data_byte = 8'h0A;
    return t;
  endfunction

  // Directed table: reset budget, every opcode, escapes, numeric extremes.
  typedef struct {
    in_word_t tok;
    string    exp;  // typed text, empty where the predictor decides
  } row_t;

  row_t        directed[$];
  int unsigned sent;

  function automatic void add_row(input in_word_t t, input string e);
    row_t r;
    r.tok = t;
    r.exp = e;
    directed.push_back(r);
  endfunction

  initial begin
    in_word_t tk;
    logic [3:0] op;
    in_valid_i   = 1'b0;
    in_word_i    = '0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    mismatches   = 0;
    long_hold    = 1'b0;
    budget       = MaxBytesReset;
    have_fields  = 1'b0;
    chars_sent   = '0;
    ovf_sticky   = 1'b0;
    rst_ni       = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(make_token(OP_TABLE,   "m", 0, 0, 0), "m");
    add_row(make_token(OP_TABLE,   " ", 0, 0, 0), "\\ ");
    add_row(make_token(OP_TAG,     0, 0, 0, 0), ",");
    add_row(make_token(OP_NAME,    "=", 0, 0, 0), "\\=");
    add_row(make_token(OP_EQUALS,  0, 0, 0, 0), "=");
    add_row(make_token(OP_TAGVAL,  8'h0A, 0, 0, 0), "\\n");
    add_row(make_token(OP_TAGVAL,  8'h0D, 0, 0, 0), "\\r");
    add_row(make_token(OP_TAGVAL,  ",", 0, 0, 0), "\\,");
    add_row(make_token(OP_FIELD,   0, 0, 0, 0), " ");
    add_row(make_token(OP_FIELD,   0, 0, 0, 0), ",");
    add_row(make_token(OP_QUOTE,   0, 0, 0, 0), "\"");
    add_row(make_token(OP_STRING,  "\\", 0, 0, 0), "\\\\");
    add_row(make_token(OP_STRING,  "\"", 0, 0, 0), "\\\"");
    add_row(make_token(OP_STRING,  8'hFF, 0, 0, 0), "");
    add_row(make_token(OP_STRING,  8'h0D, 0, 0, 0), "\\r");
    add_row(make_token(OP_BOOL,    0, 0, 0, 1), "t");
    add_row(make_token(OP_BOOL,    0, 0, 0, 0), "f");
    add_row(make_token(OP_INT,     0, 64'h8000_0000_0000_0000, 0, 0), "-9223372036854775808i");
    add_row(make_token(OP_INT,     0, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0), "9223372036854775807i");
    add_row(make_token(OP_INT,     0, 64'd0, 0, 0), "0i");
    add_row(make_token(OP_TSFIELD, 0, 64'd9223372036, 3, 0), "9223372036000000000t");
    add_row(make_token(OP_TSFIELD, 0, -64'd9223372037, 3, 0), "");
    add_row(make_token(4'd13,      0, 0, 0, 0), "");
    add_row(make_token(OP_ENDTIME, 0, 64'h7FFF_FFFF_FFFF_FFFF, 1, 0), "");
    add_row(make_token(OP_ENDNOW,  0, 0, 0, 0), "");
    foreach (directed[i]) begin
      typed_exp.push_back(directed[i].exp);
      send_token(directed[i].tok, 1'b0);
    end
    wait_idle();

    // Random rows in phases, each with its own budget, extremes among them.
    sent = 0;
    for (int phase = 0; phase < 5; phase++) begin
      wait_idle();
      case (phase)
        0: set_budget(29'h1FFF_FFFF);
        1: set_budget(29'd1);
        2: set_budget(29'd300);
        3: set_budget(29'h1000_0000);
        default: set_budget(29'd2000);
      endcase
      // budget counts from reset and stays sticky; a fresh budget moves only the limit, not the count
      if (phase == 3) long_hold = 1'b1;
      while (sent < NumRandom * (phase + 1) / 5) begin
        int kind;
        kind = $urandom_range(0, 19);
        if (kind < 15) begin
          // well-formed row: table, tags, fields, line end
          send_token(random_token(OP_TABLE), 1'b0);
          repeat ($urandom_range(0, 2)) begin
            send_token(random_token(OP_TAG), 1'b0);
            send_token(random_token(OP_NAME), 1'b0);
            send_token(random_token(OP_EQUALS), 1'b0);
            send_token(random_token(OP_TAGVAL), 1'b0);
            sent += 4;
          end
          repeat ($urandom_range(1, 2)) begin
            send_token(random_token(OP_FIELD), 1'b0);
            send_token(random_token(OP_NAME), 1'b0);
            send_token(random_token(OP_EQUALS), 1'b0);
            op = 4'($urandom_range(0, 2));
            if (op == 0) begin
              send_token(random_token(OP_QUOTE), 1'b0);
              send_token(random_token(OP_STRING), 1'b0);
              send_token(random_token(OP_QUOTE), 1'b0);
              sent += 2;
            end else if (op == 1) begin
              send_token(random_token(OP_BOOL), 1'b0);
            end else begin
              send_token(random_token($urandom_range(0, 1) ? OP_INT : OP_TSFIELD), 1'b0);
            end
            sent += 4;
          end
          send_token(random_token($urandom_range(0, 1) ? OP_ENDTIME : OP_ENDNOW), 1'b0);
          sent += 2;
        end else begin
          tk = random_token(4'($urandom_range(0, 15)));
          send_token(tk, 1'b0);
          if (tk.opcode <= OP_ENDNOW) sent++;
        end
      end
    end

    wait_idle();
    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
